>>> rtl/bts_pkg.sv
// Shared types and constants for the bilinear texture sampler.
`default_nettype none

package bts_pkg;

    // Fixed-point format and texture limits.
    localparam int FRAC_BITS = 16;
    localparam int MAX_SIDE  = 256;

    localparam int COORD_W    = 24;
    localparam int SIDE_W     = 9;
    localparam int NC_W       = FRAC_BITS + 1;
    localparam int POS_W      = FRAC_BITS + SIDE_W;
    localparam int ADDR_W     = 2 * SIDE_W;
    localparam int SAMP_W     = 8 + FRAC_BITS;
    localparam int MUL_W      = SAMP_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 2 * SAMP_W + 3;
    localparam int M_W        = ACC_W - 2 * FRAC_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [NC_W-1:0]      ONE_FX     = NC_W'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] HALF_FX    = FRAC_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [SAMP_W-1:0]    FULL_SCALE = SAMP_W'(255) << FRAC_BITS;
    localparam logic [ACC_W-1:0]     DEN_HALF   = ACC_W'(255) << (2 * FRAC_BITS - 1);
    localparam logic [15:0]          DIV_LIMIT  = 16'd65025;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE_U   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE_V   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_VALID = 3'd4;

    // Operation codes of an input transaction.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Step codes inside the sequencer states.
    localparam logic [2:0] STEP_LO    = 3'd0;
    localparam logic [2:0] STEP_HI    = 3'd1;
    localparam logic [2:0] STEP_TOP   = 3'd0;
    localparam logic [2:0] STEP_BOT   = 3'd1;
    localparam logic [2:0] STEP_FULL  = 3'd2;
    localparam logic [2:0] STEP_MIX   = 3'd0;
    localparam logic [2:0] STEP_BG    = 3'd1;
    localparam logic [2:0] FETCH_FIRST = 3'd0;
    localparam logic [2:0] FETCH_LAST  = 3'd4;
    localparam logic [1:0] CH_LAST_LERP  = 2'd3;
    localparam logic [1:0] CH_LAST_BLEND = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AXIS,
        S_ROWS,
        S_FETCH,
        S_LERP,
        S_BLEND,
        S_SEND
    } state_t;

    typedef struct packed {
        logic [SIDE_W-1:0]    lo;
        logic [SIDE_W-1:0]    hi;
        logic [FRAC_BITS-1:0] frac;
    } axis_t;

endpackage

`default_nettype wire

>>> rtl/bilinear_texture_sampler.sv
// Top level of the bilinear texture sampler: sequencer, shared multiplier and texel memory.
`default_nettype none

// Channel   Handshake            Payload
// -------   ------------------   ----------------------------------------------------------
// input     in_valid / in_stall  operation, texel_index, texel_rgba, coord_u, coord_v,
//                                background_rgb, use_texture
// output    out_valid/out_stall  red, green, blue
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A texel write leaves the sequencer idle, and a new transaction is accepted in the next cycle.
// A background-only sample passes through the send state into the output register.
// A textured sample stalls the input until it leaves the send state, since the single
// multiplier needs an issue and a consume phase for each of 22 products, and the
// single-port texel memory gives four registered reads.
// Reset clears control and configuration only; the texel store holds garbage until written.
// A stalled result waits in the output register while the next transaction is taken; a
// finished sample holds in its send state until that register is free.

module bilinear_texture_sampler #(
    parameter int TEXEL_DEPTH = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [15:0]                         texel_index,
    input  logic [31:0]                         texel_rgba,
    input  logic signed [bts_pkg::COORD_W-1:0]  coord_u,
    input  logic signed [bts_pkg::COORD_W-1:0]  coord_v,
    input  logic [23:0]                         background_rgb,
    input  logic                                use_texture,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          red,
    output logic [7:0]                          green,
    output logic [7:0]                          blue,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import bts_pkg::*;

    localparam int DEPTH_W = $clog2(TEXEL_DEPTH);

    // Clamp mode pins the coordinate into [0,1]; repeat mode keeps the two's complement
    // fraction, which is the value minus its floor even for negative inputs.
    function automatic logic [NC_W-1:0] axis_norm(input logic [COORD_W-1:0] raw,
                                                   input logic rep);
        logic [NC_W-1:0] r;
        if (rep)
            r = {1'b0, raw[FRAC_BITS-1:0]};
        else if (raw[COORD_W-1])
            r = '0;
        else if (raw > COORD_W'(ONE_FX))
            r = ONE_FX;
        else
            r = raw[NC_W-1:0];
        return r;
    endfunction

    // The coordinate never exceeds one, so the integer part never passes size-1.
    function automatic axis_t split_axis(input logic [POS_W-1:0] pos,
                                         input logic [SIDE_W-1:0] size);
        axis_t           a;
        logic [SIDE_W:0] nxt;
        a.lo   = pos[POS_W-1:FRAC_BITS];
        nxt    = {1'b0, a.lo} + 1'b1;
        a.hi   = (nxt < {1'b0, size}) ? nxt[SIDE_W-1:0] : a.lo;
        a.frac = pos[FRAC_BITS-1:0];
        return a;
    endfunction

    function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] s);
        logic [SIDE_W-1:0] r;
        if (32'(s) > MAX_SIDE)
            r = SIDE_W'(MAX_SIDE);
        else
            r = s;
        return r;
    endfunction

    // Channel 0 is the top byte (red), channel 3 the bottom byte (alpha).
    function automatic logic [7:0] word_byte(input logic [31:0] word, input logic [1:0] ch);
        logic [7:0] b;
        case (ch)
            2'd0:    b = word[31:24];
            2'd1:    b = word[23:16];
            2'd2:    b = word[15:8];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

    // Control and configuration state.
    state_t              state_reg, state_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [1:0]          ch_reg, ch_next;
    logic                ph_reg, ph_next;
    logic [SIDE_W-1:0]   tex_width_reg, tex_height_reg;
    logic                wrap_mode_u_reg, wrap_mode_v_reg, texture_valid_reg;
    logic                out_valid_reg;

    // Datapath registers.
    logic [NC_W-1:0]       cu_reg, cv_reg;
    logic [23:0]           bg_reg;
    logic [SIDE_W-1:0]     x0_reg, x1_reg, y0_reg, y1_reg;
    logic [FRAC_BITS-1:0]  tx_reg, ty_reg;
    logic [ADDR_W-1:0]     row0_reg, row1_reg;
    logic [31:0]           t_reg [4];
    logic [SAMP_W-1:0]     top_reg, bot_reg;
    logic [SAMP_W-1:0]     samp_reg [4];
    logic [ACC_W-1:0]      acc_reg;
    logic [7:0]            res_reg [3];
    logic [7:0]            red_reg, green_reg, blue_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // Texel memory.
    logic [31:0]         texel_mem [TEXEL_DEPTH];
    logic [31:0]         mem_rdata_reg;
    logic                rd_oor_reg;
    logic [DEPTH_W-1:0]  mem_addr;
    logic                mem_we;
    logic [ADDR_W-1:0]   fetch_addr;

    // Combinational helpers.
    logic                in_accept, cfg_accept, bypass, mul_load, out_load;
    logic [SIDE_W-1:0]   w_side, h_side, w_last, h_last;
    axis_t               ax;
    logic [7:0]          ca, cb, cc, cd, bg_byte;
    logic signed [8:0]   diff_ab, diff_cd;
    logic signed [MUL_W-1:0] diff_bt;
    logic [SAMP_W-1:0]   inv_alpha;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] top_sum, bot_sum, full_sum;
    logic [ACC_W-1:0]    blend_num;
    logic [M_W-1:0]      blend_m;
    logic [15:0]         blend_mc;
    logic [16:0]         div_sum;

    assign in_accept  = in_valid && !in_stall;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign w_side = sat_side(tex_width_reg);
    assign h_side = sat_side(tex_height_reg);
    assign w_last = w_side - 1'b1;
    assign h_last = h_side - 1'b1;

    // Untextured surfaces, an unloaded texture and an empty side all show the background.
    assign bypass = !use_texture || !texture_valid_reg || (w_side == '0) || (h_side == '0);

    // Corner bytes of the current channel: t00, t10, t01, t11.
    assign ca      = word_byte(t_reg[0], ch_reg);
    assign cb      = word_byte(t_reg[1], ch_reg);
    assign cc      = word_byte(t_reg[2], ch_reg);
    assign cd      = word_byte(t_reg[3], ch_reg);
    assign bg_byte = word_byte({bg_reg, 8'h00}, ch_reg);

    // Each lerp is written as lo*ONE + (hi-lo)*t, which is exact and needs one product.
    assign diff_ab   = $signed({1'b0, cb}) - $signed({1'b0, ca});
    assign diff_cd   = $signed({1'b0, cd}) - $signed({1'b0, cc});
    assign diff_bt   = $signed({1'b0, bot_reg}) - $signed({1'b0, top_reg});
    assign inv_alpha = FULL_SCALE - samp_reg[3];

    assign ax = split_axis(prod_reg[POS_W-1:0], (cnt_reg == STEP_LO) ? w_side : h_side);

    assign top_sum  = prod_reg + $signed(PROD_W'({ca, {FRAC_BITS{1'b0}}}));
    assign bot_sum  = prod_reg + $signed(PROD_W'({cc, {FRAC_BITS{1'b0}}}));
    assign full_sum = prod_reg + $signed(PROD_W'({top_reg, {FRAC_BITS{1'b0}}}))
                    + $signed(PROD_W'(HALF_FX));

    // The blend divides by 255 * 2^2F: the power of two is a shift, and the remaining
    // division by 255 uses the shift-and-add form, exact below the saturation limit.
    assign blend_num = acc_reg + ACC_W'({prod_reg[SAMP_W+7:0], {FRAC_BITS{1'b0}}});
    assign blend_m   = blend_num[ACC_W-1:2*FRAC_BITS];
    assign blend_mc  = (blend_m > M_W'(DIV_LIMIT)) ? DIV_LIMIT : blend_m[15:0];
    assign div_sum   = 17'(blend_mc) + 17'(blend_mc >> 8) + 17'd1;

    // Four neighbor addresses in the order t00, t10, t01, t11.
    always_comb
    begin
        case (cnt_reg)
            3'd0:    fetch_addr = row0_reg + ADDR_W'(x0_reg);
            3'd1:    fetch_addr = row0_reg + ADDR_W'(x1_reg);
            3'd2:    fetch_addr = row1_reg + ADDR_W'(x0_reg);
            default: fetch_addr = row1_reg + ADDR_W'(x1_reg);
        endcase
    end

    assign mem_we   = in_accept && (operation == OP_WRITE) && (32'(texel_index) < TEXEL_DEPTH);
    assign mem_addr = mem_we ? DEPTH_W'(texel_index) : DEPTH_W'(fetch_addr);

    // Operand selection of the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_AXIS:
            begin
                if (cnt_reg == STEP_LO)
                begin
                    mul_a = MUL_W'(cu_reg);
                    mul_b = MUL_W'(w_last);
                end
                else
                begin
                    mul_a = MUL_W'(cv_reg);
                    mul_b = MUL_W'(h_last);
                end
            end
            S_ROWS:
            begin
                mul_a = (cnt_reg == STEP_LO) ? MUL_W'(y0_reg) : MUL_W'(y1_reg);
                mul_b = MUL_W'(w_side);
            end
            S_LERP:
            begin
                case (cnt_reg)
                    STEP_TOP:
                    begin
                        mul_a = MUL_W'(diff_ab);
                        mul_b = MUL_W'(tx_reg);
                    end
                    STEP_BOT:
                    begin
                        mul_a = MUL_W'(diff_cd);
                        mul_b = MUL_W'(tx_reg);
                    end
                    default:
                    begin
                        mul_a = diff_bt;
                        mul_b = MUL_W'(ty_reg);
                    end
                endcase
            end
            S_BLEND:
            begin
                if (cnt_reg == STEP_MIX)
                begin
                    mul_a = MUL_W'(samp_reg[ch_reg]);
                    mul_b = MUL_W'(samp_reg[3]);
                end
                else
                begin
                    mul_a = MUL_W'(bg_byte);
                    mul_b = MUL_W'(inv_alpha);
                end
            end
            default: ;
        endcase
    end

    // Next state of the sequencer. Multiply states alternate an issue and a consume phase.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ch_next    = ch_reg;
        ph_next    = ph_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (operation == OP_SAMPLE))
                    state_next = bypass ? S_SEND : S_AXIS;
            end
            S_AXIS, S_ROWS:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    if (cnt_reg == STEP_HI)
                    begin
                        cnt_next   = '0;
                        state_next = (state_reg == S_AXIS) ? S_ROWS : S_FETCH;
                    end
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FETCH:
            begin
                if (cnt_reg == FETCH_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_LERP;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_LERP:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    if (cnt_reg == STEP_FULL)
                    begin
                        cnt_next = '0;
                        if (ch_reg == CH_LAST_LERP)
                        begin
                            ch_next    = '0;
                            state_next = S_BLEND;
                        end
                        else
                            ch_next = ch_reg + 1'b1;
                    end
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            S_BLEND:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    if (cnt_reg == STEP_BG)
                    begin
                        cnt_next = '0;
                        if (ch_reg == CH_LAST_BLEND)
                        begin
                            ch_next    = '0;
                            state_next = S_SEND;
                        end
                        else
                            ch_next = ch_reg + 1'b1;
                    end
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SEND:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        cfg_ready = 1'b1;
        out_load  = (state_reg == S_SEND) && (!out_valid_reg || !out_stall);
        case (state_reg)
            S_AXIS, S_ROWS, S_LERP, S_BLEND: mul_load = !ph_reg;
            default:                         mul_load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cnt_reg           <= '0;
            ch_reg            <= '0;
            ph_reg            <= 1'b0;
            tex_width_reg     <= SIDE_W'(1);
            tex_height_reg    <= SIDE_W'(1);
            wrap_mode_u_reg   <= 1'b0;
            wrap_mode_v_reg   <= 1'b0;
            texture_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ch_reg    <= ch_next;
            ph_reg    <= ph_next;
            if (cfg_accept)
            begin
                case (cfg_index)
                    CFG_TEX_WIDTH:     tex_width_reg     <= cfg_data;
                    CFG_TEX_HEIGHT:    tex_height_reg    <= cfg_data;
                    CFG_WRAP_MODE_U:   wrap_mode_u_reg   <= cfg_data[0];
                    CFG_WRAP_MODE_V:   wrap_mode_v_reg   <= cfg_data[0];
                    CFG_TEXTURE_VALID: texture_valid_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Single-port texel memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            texel_mem[mem_addr] <= texel_rgba;
        else
            mem_rdata_reg <= texel_mem[mem_addr];
        rd_oor_reg <= (32'(fetch_addr) >= TEXEL_DEPTH);
    end

    // Shared multiplier.
    always_ff @(posedge clk)
    begin
        if (mul_load)
            prod_reg <= mul_a * mul_b;
    end

    // Datapath: captures the transaction and consumes each product in its own phase.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cu_reg     <= axis_norm(coord_u, wrap_mode_u_reg);
            cv_reg     <= axis_norm(coord_v, wrap_mode_v_reg);
            bg_reg     <= background_rgb;
            res_reg[0] <= background_rgb[23:16];
            res_reg[1] <= background_rgb[15:8];
            res_reg[2] <= background_rgb[7:0];
        end

        if (ph_reg)
        begin
            case (state_reg)
                S_AXIS:
                begin
                    if (cnt_reg == STEP_LO)
                    begin
                        x0_reg <= ax.lo;
                        x1_reg <= ax.hi;
                        tx_reg <= ax.frac;
                    end
                    else
                    begin
                        y0_reg <= ax.lo;
                        y1_reg <= ax.hi;
                        ty_reg <= ax.frac;
                    end
                end
                S_ROWS:
                begin
                    if (cnt_reg == STEP_LO)
                        row0_reg <= prod_reg[ADDR_W-1:0];
                    else
                        row1_reg <= prod_reg[ADDR_W-1:0];
                end
                S_LERP:
                begin
                    case (cnt_reg)
                        STEP_TOP: top_reg <= top_sum[SAMP_W-1:0];
                        STEP_BOT: bot_reg <= bot_sum[SAMP_W-1:0];
                        default:  samp_reg[ch_reg] <= full_sum[FRAC_BITS +: SAMP_W];
                    endcase
                end
                S_BLEND:
                begin
                    if (cnt_reg == STEP_MIX)
                        acc_reg <= ACC_W'(prod_reg[2*SAMP_W-1:0]) + DEN_HALF;
                    else
                        res_reg[ch_reg] <= div_sum[15:8];
                end
                default: ;
            endcase
        end

        // Read data arrives in the cycle after its address; an address past the store reads zero.
        if ((state_reg == S_FETCH) && (cnt_reg != FETCH_FIRST))
            t_reg[2'(cnt_reg - 1'b1)] <= rd_oor_reg ? 32'd0 : mem_rdata_reg;

        if (out_load)
        begin
            red_reg   <= res_reg[0];
            green_reg <= res_reg[1];
            blue_reg  <= res_reg[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    // A texel write never starts the sequencer.
    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (operation == OP_WRITE) |=> state_reg == S_IDLE)
        else $error("texel write left the idle state");

    // A background-only sample goes straight to the output stage.
    a_bypass_direct: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (operation == OP_SAMPLE) && bypass |=> state_reg == S_SEND)
        else $error("background-only sample entered the arithmetic sequence");

    // Neighbor columns and rows stay inside the texture.
    a_neighbors_inside: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROWS |-> (x1_reg < w_side) && (y1_reg < h_side) && (x0_reg <= x1_reg))
        else $error("neighbor texel outside the texture");

    // Every fetched address lies inside the width by height texel block.
    a_fetch_inside: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FETCH |-> 32'(fetch_addr) < (32'(w_side) * 32'(h_side)))
        else $error("texel fetch address outside the texture");

    // Step counters and phase are clear whenever the block waits for a transaction.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> (cnt_reg == '0) && (ch_reg == '0) && !ph_reg)
        else $error("sequencer counters not cleared in idle");

endmodule

`default_nettype wire
